>>> rtl/core/preemption_overhead_trace_filter_unit_defines.svh
// assertion macros used by the checker file
`ifndef PREEMPTION_OVERHEAD_TRACE_FILTER_UNIT_DEFINES_SVH
`define PREEMPTION_OVERHEAD_TRACE_FILTER_UNIT_DEFINES_SVH

// property checked at every clock edge outside reset
`define POTF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every clock edge, reset included
`define POTF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/potf_pkg.sv
`timescale 1ns / 1ps

package potf_pkg;

  localparam int CPU_BITS_DEFAULT = 8;

  localparam int KIND_W = 3;
  localparam int TIME_W = 63;
  localparam int CPU_W = 8;
  localparam int LEN_W = 63;
  localparam int CNT_W = 16;
  localparam int OVH_W = 64;

  // slave tdata layout
  localparam int IN_TIME_LO = 0;
  localparam int IN_CPU_LO = IN_TIME_LO + TIME_W;
  localparam int IN_LEN_LO = IN_CPU_LO + CPU_W;
  localparam int IN_DATA_W = ((IN_LEN_LO + LEN_W + 7) / 8) * 8;

  // master tdata layout
  localparam int OUT_CUR_LO = 0;
  localparam int OUT_PREV_LO = OUT_CUR_LO + CPU_W;
  localparam int OUT_OVH_LO = OUT_PREV_LO + CPU_W;
  localparam int OUT_LEN_LO = OUT_OVH_LO + OVH_W;
  localparam int OUT_DATA_W = ((OUT_LEN_LO + LEN_W + 7) / 8) * 8;

  localparam logic [KIND_W-1:0] KIND_HOT_OK = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HOT_BAD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PRE_OK = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PRE_BAD = 3'd3;

  localparam logic [CNT_W-1:0] ROUND_LEN_RESET = 16'd1;

endpackage

>>> rtl/core/preemption_overhead_trace_filter_unit.sv
`timescale 1ns / 1ps

// an accepted input item passes the input stage and then the result stage on its way to the master side
// throughput: one item per cycle; a stalled result keeps one item in the input stage,
// after which s_tready stays low until the result is taken
// items that make no result still need a free result stage to leave the input stage
// reset (rst, synchronous, active high) empties both stages, clears the round
// counters and the last cpu, and sets the round length to 1

module preemption_overhead_trace_filter_unit #(
  parameter int CPU_BITS = potf_pkg::CPU_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration: round length
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [potf_pkg::CNT_W-1:0]         cfg_data,
  // input records
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // record time, cpu_number, preempt_length, zero pad
  input  logic [potf_pkg::IN_DATA_W-1:0]     s_tdata,
  // record_kind
  input  logic [potf_pkg::KIND_W-1:0]        s_tuser,
  // results
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // current_cpu, previous_cpu, overhead, length_out, zero pad
  output logic [potf_pkg::OUT_DATA_W-1:0]    m_tdata
);

  localparam int KEEP = (CPU_BITS < potf_pkg::CPU_W) ? CPU_BITS : potf_pkg::CPU_W;

  // configuration and filter state
  logic [potf_pkg::CNT_W-1:0]  round_len;
  logic [potf_pkg::CNT_W-1:0]  round_count;
  logic [potf_pkg::CNT_W-1:0]  valid_count;
  logic                        clean_so_far;
  logic                        have_hot_min;
  logic [potf_pkg::TIME_W-1:0] hot_minimum;
  logic [KEEP-1:0]             seen_cpu;

  // input stage
  logic                        st_valid;
  logic [potf_pkg::KIND_W-1:0] st_kind;
  logic [potf_pkg::TIME_W-1:0] st_time;
  logic [KEEP-1:0]             st_cpu;
  logic [potf_pkg::LEN_W-1:0]  st_len;

  // result stage
  logic [potf_pkg::CPU_W-1:0]  res_cur;
  logic [potf_pkg::CPU_W-1:0]  res_prev;
  logic [potf_pkg::OVH_W-1:0]  res_ovh;
  logic [potf_pkg::LEN_W-1:0]  res_len;

  logic                        out_free;
  logic                        advance;
  logic                        is_hot;
  logic                        is_pre;
  logic                        good_hot;
  logic                        emit;
  logic                        round_close;
  logic [potf_pkg::CNT_W-1:0]  round_inc;
  logic [potf_pkg::CNT_W-1:0]  valid_inc;
  logic [potf_pkg::CNT_W-1:0]  valid_after;
  logic [potf_pkg::TIME_W-1:0] min_after;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign advance   = st_valid && out_free;
  assign s_tready  = !st_valid || out_free;

  always_comb begin
    is_hot      = (st_kind == potf_pkg::KIND_HOT_OK) || (st_kind == potf_pkg::KIND_HOT_BAD);
    is_pre      = (st_kind == potf_pkg::KIND_PRE_OK) || (st_kind == potf_pkg::KIND_PRE_BAD);
    good_hot    = clean_so_far && (st_kind == potf_pkg::KIND_HOT_OK);
    emit        = have_hot_min && (st_kind == potf_pkg::KIND_PRE_OK);
    round_inc   = round_count + 1'b1;
    // saturates so the count stays nonzero for the rest of the round
    valid_inc   = (&valid_count) ? valid_count : valid_count + 1'b1;
    valid_after = good_hot ? valid_inc : valid_count;
    // the first valid read of a round replaces the minimum
    min_after   = (good_hot && ((valid_inc == potf_pkg::CNT_W'(1)) || (st_time < hot_minimum)))
                  ? st_time : hot_minimum;
    round_close = (round_inc == round_len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round_len    <= potf_pkg::ROUND_LEN_RESET;
      round_count  <= '0;
      valid_count  <= '0;
      clean_so_far <= 1'b1;
      have_hot_min <= 1'b0;
      hot_minimum  <= '0;
      seen_cpu     <= '0;
      st_valid     <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        round_len <= cfg_data;
      end

      if (s_tvalid && s_tready) begin
        st_valid <= 1'b1;
      end else if (advance) begin
        st_valid <= 1'b0;
      end

      if (advance && is_hot) begin
        hot_minimum <= min_after;
        if (round_close) begin
          have_hot_min <= (valid_after != '0);
          round_count  <= '0;
          valid_count  <= '0;
          clean_so_far <= 1'b1;
        end else begin
          round_count  <= round_inc;
          valid_count  <= valid_after;
          clean_so_far <= good_hot;
        end
      end
      if (advance && (is_hot || is_pre)) begin
        seen_cpu <= st_cpu;
      end

      if (out_free) begin
        m_tvalid <= advance && emit;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      st_kind <= s_tuser;
      st_time <= s_tdata[potf_pkg::IN_TIME_LO +: potf_pkg::TIME_W];
      st_cpu  <= s_tdata[potf_pkg::IN_CPU_LO +: KEEP];
      st_len  <= s_tdata[potf_pkg::IN_LEN_LO +: potf_pkg::LEN_W];
    end
    if (advance && emit && out_free) begin
      res_cur  <= potf_pkg::CPU_W'(st_cpu);
      res_prev <= potf_pkg::CPU_W'(seen_cpu);
      res_ovh  <= potf_pkg::OVH_W'(st_time) - potf_pkg::OVH_W'(hot_minimum);
      res_len  <= st_len;
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[potf_pkg::OUT_CUR_LO +: potf_pkg::CPU_W]  = res_cur;
    m_tdata[potf_pkg::OUT_PREV_LO +: potf_pkg::CPU_W] = res_prev;
    m_tdata[potf_pkg::OUT_OVH_LO +: potf_pkg::OVH_W]  = res_ovh;
    m_tdata[potf_pkg::OUT_LEN_LO +: potf_pkg::LEN_W]  = res_len;
  end

endmodule

>>> rtl/core/potf_checker.sv
`timescale 1ns / 1ps
`include "preemption_overhead_trace_filter_unit_defines.svh"

module potf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [potf_pkg::CNT_W-1:0]     cfg_data,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [potf_pkg::IN_DATA_W-1:0] s_tdata,
  input logic [potf_pkg::KIND_W-1:0]    s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [potf_pkg::OUT_DATA_W-1:0] m_tdata
);

  // a stalled result keeps its value
  `POTF_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

  // nothing is offered right after reset
  `POTF_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result valid after reset")

  // a fresh result comes from an accepted item that passed through the input stage
  `POTF_ASSERT(a_origin, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2), "result without a source item")

  // only a valid preemption record makes a result
  `POTF_ASSERT(a_kind, $rose(m_tvalid) |-> $past(s_tuser, 2) == potf_pkg::KIND_PRE_OK, "result from a non-preemption record")

endmodule

bind preemption_overhead_trace_filter_unit potf_checker u_potf_checker (.*);

>>> tb/preemption_overhead_trace_filter_unit_test.sv
`timescale 1ns / 1ps

module preemption_overhead_trace_filter_unit_test;

  localparam int KIND_W = potf_pkg::KIND_W;
  localparam int TIME_W = potf_pkg::TIME_W;
  localparam int CPU_W = potf_pkg::CPU_W;
  localparam int LEN_W = potf_pkg::LEN_W;
  localparam int CNT_W = potf_pkg::CNT_W;
  localparam int OVH_W = potf_pkg::OVH_W;
  localparam int IN_DATA_W = potf_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = potf_pkg::OUT_DATA_W;
  localparam int IN_TIME_LO = potf_pkg::IN_TIME_LO;
  localparam int IN_CPU_LO = potf_pkg::IN_CPU_LO;
  localparam int IN_LEN_LO = potf_pkg::IN_LEN_LO;
  localparam int OUT_CUR_LO = potf_pkg::OUT_CUR_LO;
  localparam int OUT_PREV_LO = potf_pkg::OUT_PREV_LO;
  localparam int OUT_OVH_LO = potf_pkg::OUT_OVH_LO;
  localparam int OUT_LEN_LO = potf_pkg::OUT_LEN_LO;
  localparam logic [KIND_W-1:0] KIND_HOT_OK = potf_pkg::KIND_HOT_OK;
  localparam logic [KIND_W-1:0] KIND_HOT_BAD = potf_pkg::KIND_HOT_BAD;
  localparam logic [KIND_W-1:0] KIND_PRE_OK = potf_pkg::KIND_PRE_OK;
  localparam logic [KIND_W-1:0] KIND_PRE_BAD = potf_pkg::KIND_PRE_BAD;
  localparam logic [CNT_W-1:0] ROUND_LEN_RESET = potf_pkg::ROUND_LEN_RESET;

  localparam logic [KIND_W-1:0] KIND_OTHER = 3'd4;
  localparam logic [KIND_W-1:0] KIND_LAST_CODE = 3'd7;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [CNT_W-1:0] ROUND_LEN_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] ROUND_LEN_WRAP = '0;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [CPU_W-1:0] current_cpu;
    logic [CPU_W-1:0] previous_cpu;
    logic [OVH_W-1:0] overhead;
    logic [LEN_W-1:0] length_out;
  } overhead_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [KIND_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // predicted filter state
  logic [CNT_W-1:0] round_len;
  logic [CNT_W-1:0] round_cnt;
  logic [CNT_W-1:0] valid_cnt;
  bit clean_so_far;
  bit have_min;
  logic [TIME_W-1:0] hot_min;
  logic [CPU_W-1:0] seen_cpu;

  overhead_result_t pending_overheads[$];
  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  preemption_overhead_trace_filter_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("preemption_overhead_trace_filter_unit_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic bit filter_record(input logic [KIND_W-1:0] kind,
                                       input logic [TIME_W-1:0] t,
                                       input logic [CPU_W-1:0] cpu,
                                       input logic [LEN_W-1:0] plen,
                                       output overhead_result_t res);
    bit hit;
    hit = 1'b0;
    res = '0;
    if (kind == KIND_HOT_OK || kind == KIND_HOT_BAD) begin
      round_cnt = round_cnt + 1'b1;
      if (clean_so_far && kind == KIND_HOT_OK) begin
        if (valid_cnt != ROUND_LEN_MAX) valid_cnt = valid_cnt + 1'b1;
        if (valid_cnt == 1 || t < hot_min) hot_min = t;
      end else begin
        // first invalid read spoils the rest of the round
        clean_so_far = 1'b0;
      end
      if (round_cnt == round_len) begin
        have_min = (valid_cnt != 0);
        valid_cnt = '0;
        round_cnt = '0;
        clean_so_far = 1'b1;
      end
      seen_cpu = cpu;
    end else if (kind == KIND_PRE_OK || kind == KIND_PRE_BAD) begin
      if (have_min && kind == KIND_PRE_OK) begin
        res.current_cpu = cpu;
        res.previous_cpu = seen_cpu;
        res.overhead = {1'b0, t} - {1'b0, hot_min};
        res.length_out = plen;
        hit = 1'b1;
      end
      seen_cpu = cpu;
    end
    return hit;
  endfunction

  function automatic logic [TIME_W-1:0] rand_cycles();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return raw[TIME_W-1:0];
      1: return TIME_W'($urandom_range(1000));
      2: return TIME_MAX - TIME_W'($urandom_range(3));
      default: return TIME_W'(raw[31:0]);
    endcase
  endfunction

  task automatic note_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at cycle %0d: expected %h, got %h",
               field, cycle_count, want, got);
  endtask

  always @(posedge clk) begin
    overhead_result_t want;
    overhead_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.current_cpu = m_tdata[OUT_CUR_LO +: CPU_W];
      got.previous_cpu = m_tdata[OUT_PREV_LO +: CPU_W];
      got.overhead = m_tdata[OUT_OVH_LO +: OVH_W];
      got.length_out = m_tdata[OUT_LEN_LO +: LEN_W];
      if (pending_overheads.size() == 0) begin
        note_mismatch("unexpected item", '0, got.overhead);
      end else begin
        want = pending_overheads.pop_front();
        if (got.current_cpu != want.current_cpu)
          note_mismatch("current_cpu", 64'(want.current_cpu), 64'(got.current_cpu));
        if (got.previous_cpu != want.previous_cpu)
          note_mismatch("previous_cpu", 64'(want.previous_cpu), 64'(got.previous_cpu));
        if (got.overhead != want.overhead)
          note_mismatch("overhead", want.overhead, got.overhead);
        if (got.length_out != want.length_out)
          note_mismatch("length_out", 64'(want.length_out), 64'(got.length_out));
      end
    end
  end

  task automatic send_record(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] t,
                             input logic [CPU_W-1:0] cpu, input logic [LEN_W-1:0] plen);
    logic [IN_DATA_W-1:0] word;
    overhead_result_t res;
    word = '0;
    word[IN_TIME_LO +: TIME_W] = t;
    word[IN_CPU_LO +: CPU_W] = cpu;
    word[IN_LEN_LO +: LEN_W] = plen;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    s_tuser <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (filter_record(kind, t, cpu, plen, res)) pending_overheads.push_back(res);
  endtask

  // wait for every predicted item, then let the result stage empty
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_overheads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_round_len(input logic [CNT_W-1:0] len);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    round_len = len;
  endtask

  task automatic test_reset_defaults();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // no closed round yet, so no result
    send_record(KIND_PRE_OK, 63'd10, 8'hff, TIME_MAX);
    send_record(KIND_PRE_BAD, TIME_MAX, 8'h00, 63'd0);
    for (int k = KIND_OTHER; k <= KIND_LAST_CODE; k++)
      send_record(KIND_W'(k), TIME_MAX, 8'haa, TIME_MAX);
    send_record(KIND_HOT_OK, TIME_MAX, 8'h00, 63'd0);
    // negative overhead, then zero
    send_record(KIND_PRE_OK, 63'd0, 8'hff, TIME_MAX);
    send_record(KIND_PRE_OK, TIME_MAX, 8'h55, 63'd0);
    send_record(KIND_PRE_BAD, 63'd5, 8'h12, 63'd7);
    // round holding only an invalid read drops the minimum
    send_record(KIND_HOT_BAD, 63'd3, 8'h34, 63'd1);
    send_record(KIND_PRE_OK, 63'd9, 8'h56, 63'd2);
    send_record(KIND_HOT_OK, 63'd0, 8'h78, TIME_MAX);
    send_record(KIND_PRE_OK, TIME_MAX, 8'h9a, TIME_MAX);
  endtask

  task automatic test_round_close();
    write_round_len(16'd3);
    send_idle_pct = 20;
    recv_stall_pct = 20;
    send_record(KIND_HOT_OK, 63'd100, 8'd1, 63'd0);
    send_record(KIND_HOT_BAD, 63'd1, 8'd2, 63'd0);
    // after an invalid read this one no longer counts
    send_record(KIND_HOT_OK, 63'd5, 8'd3, 63'd0);
    send_record(KIND_PRE_OK, 63'd50, 8'd4, 63'd11);
    // running minimum of the open round is used
    send_record(KIND_HOT_OK, 63'd70, 8'd5, 63'd0);
    send_record(KIND_PRE_OK, 63'd80, 8'd6, 63'd12);
    send_record(KIND_HOT_OK, 63'd60, 8'd7, 63'd0);
    send_record(KIND_HOT_OK, 63'd90, 8'd8, 63'd0);
    send_record(KIND_PRE_OK, 63'd60, 8'd9, 63'd13);
    write_round_len(ROUND_LEN_RESET);
  endtask

  // a zero length wraps to 65536 reads, so the round stays open here
  task automatic test_zero_round_len();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_round_len(ROUND_LEN_WRAP);
    send_record(KIND_HOT_OK, 63'd40, 8'd1, 63'd0);
    send_record(KIND_HOT_OK, 63'd30, 8'd2, 63'd0);
    send_record(KIND_PRE_OK, 63'd35, 8'd3, 63'd21);
    send_record(KIND_HOT_BAD, 63'd10, 8'd4, 63'd0);
    send_record(KIND_HOT_OK, 63'd5, 8'd5, 63'd0);
    send_record(KIND_PRE_OK, TIME_MAX, 8'd6, TIME_MAX);
  endtask

  task automatic test_longest_round();
    write_round_len(ROUND_LEN_MAX);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    send_record(KIND_HOT_OK, 63'd400, 8'h01, 63'd0);
    send_record(KIND_PRE_OK, 63'd300, 8'h02, 63'd3);
    send_record(KIND_HOT_OK, 63'd200, 8'h03, 63'd0);
    send_record(KIND_HOT_BAD, 63'd100, 8'h04, 63'd0);
    send_record(KIND_PRE_OK, 63'd250, 8'h05, 63'd4);
    send_record(KIND_PRE_BAD, 63'd250, 8'h06, 63'd5);
  endtask

  task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
    logic [CNT_W-1:0] len;
    logic [KIND_W-1:0] kind;
    int pick;
    for (int i = 0; i < n; i++) begin
      if (i % 70 == 0) begin
        len = CNT_W'($urandom_range(1, 6));
        // keep the open round short enough to close soon
        if (len <= round_cnt) len = round_cnt + 1'b1;
        write_round_len(len);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
      end
      pick = $urandom_range(99);
      if (pick < 45) kind = KIND_HOT_OK;
      else if (pick < 55) kind = KIND_HOT_BAD;
      else if (pick < 85) kind = KIND_PRE_OK;
      else if (pick < 92) kind = KIND_PRE_BAD;
      else kind = KIND_W'($urandom_range(KIND_OTHER, KIND_LAST_CODE));
      send_record(kind, rand_cycles(), CPU_W'($urandom), rand_cycles());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    round_len = ROUND_LEN_RESET;
    round_cnt = '0;
    valid_cnt = '0;
    clean_so_far = 1'b1;
    have_min = 1'b0;
    hot_min = '0;
    seen_cpu = '0;
    test_reset_defaults();
    test_round_close();
    test_zero_round_len();
    test_longest_round();
    test_random_traffic(340, 6, 83);
    test_random_traffic(340, 83, 6);
    test_random_traffic(340, 0, 0);
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_overheads.size() == 0) begin
      $display("preemption_overhead_trace_filter_unit_test OK");
    end else begin
      $display("preemption_overhead_trace_filter_unit_test NOT OK");
    end
    $finish;
  end

endmodule
